// ----- src/hhist_pkg.sv -----
// ----------------------------------------------------------------------------
// hhist_pkg
// Shared types and constants for the weighted 2-D hit histogram.
// ----------------------------------------------------------------------------
package hhist_pkg;

	// Default grid side (bins per axis)
	localparam int GRID_SIDE = 1024;

	// Field widths of one input item and one result item
	localparam int COORD_W = 32;
	localparam int INTEN_W = 16;
	localparam int BIDX_W  = 10;
	localparam int BIN_W   = 32;
	localparam int CFG_W   = 32;
	localparam int CFGIX_W = 2;

	// Packed stream widths
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 32;

	// Register reset values
	localparam logic [CFG_W-1:0] WIN_MIN_RESET = '0;
	localparam logic [CFG_W-1:0] SCALE_RESET   = 32'h0001_0000;

	// Action codes carried in tuser
	localparam logic ACT_ACCUM = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFGIX_W-1:0] {
		CFG_WIN_MIN_X = 2'd0,
		CFG_WIN_MIN_Y = 2'd1,
		CFG_SCALE_X   = 2'd2,
		CFG_SCALE_Y   = 2'd3
	} cfg_reg_t;

	// Control bits of an item travelling down the pipeline
	typedef struct packed {
		logic valid;
		logic is_read;
		logic oob;
	} item_ctl_t;

	// Status from the read-modify-write stage back to the front
	typedef struct packed {
		logic advance;
		logic clearing;
	} pipe_stat_t;

endpackage

// ----- src/hhist_ram.sv -----
// ----------------------------------------------------------------------------
// hhist_ram
// Simple dual-port bin memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hhist_ram #(
	parameter int Depth = 1024,
	parameter int AddrW = 10,
	parameter int DataW = 32
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [DataW-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [DataW-1:0] rdata
);

	logic [DataW-1:0] mem_q [Depth];
	logic [DataW-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/hhist_addr.sv -----
// ----------------------------------------------------------------------------
// hhist_addr
// Bin address pipeline: window offset, scale multiply, clamp and flatten.
// ----------------------------------------------------------------------------
module hhist_addr #(
	parameter int GridSide = hhist_pkg::GRID_SIDE,
	parameter int AddrW    = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          in_xfer,
	input  logic                          action,
	input  logic [hhist_pkg::COORD_W-1:0] point_x,
	input  logic [hhist_pkg::COORD_W-1:0] point_y,
	input  logic [hhist_pkg::INTEN_W-1:0] intensity,
	input  logic [hhist_pkg::BIDX_W-1:0]  read_row,
	input  logic [hhist_pkg::BIDX_W-1:0]  read_col,
	input  logic [hhist_pkg::CFG_W-1:0]   win_min_x,
	input  logic [hhist_pkg::CFG_W-1:0]   win_min_y,
	input  logic [hhist_pkg::CFG_W-1:0]   scale_x,
	input  logic [hhist_pkg::CFG_W-1:0]   scale_y,
	output hhist_pkg::item_ctl_t          ctl_s3,
	output logic [AddrW-1:0]              addr_s3,
	output logic [hhist_pkg::INTEN_W-1:0] intensity_s3
);

	import hhist_pkg::*;

	localparam int IdxW = $clog2(GridSide);

	// Stage 1 registers
	logic                 valid_s1, read_s1;
	logic                 pos_x_s1, pos_y_s1;
	logic [COORD_W-1:0]   mag_x_s1, mag_y_s1;
	logic [INTEN_W-1:0]   inten_s1;
	logic [BIDX_W-1:0]    row_s1, col_s1;
	// Stage 2 registers
	logic                 valid_s2, read_s2;
	logic                 pos_x_s2, pos_y_s2;
	logic [2*COORD_W-1:0] prod_x_s2, prod_y_s2;
	logic [INTEN_W-1:0]   inten_s2;
	logic [BIDX_W-1:0]    row_s2, col_s2;

	logic [COORD_W:0]     diff_x, diff_y;
	logic [COORD_W-1:0]   idx_x, idx_y;
	logic [IdxW-1:0]      bin_x, bin_y;
	logic                 oob;
	logic [AddrW-1:0]     hit_addr, rd_addr;

	// Offset from the window edge, exact in one extra bit
	assign diff_x = {point_x[COORD_W-1], point_x} - {win_min_x[CFG_W-1], win_min_x};
	assign diff_y = {point_y[COORD_W-1], point_y} - {win_min_y[CFG_W-1], win_min_y};

	// Floor of the Q32.32 product, zero for points at or below the edge, clamp high
	always_comb begin
		idx_x = pos_x_s2 ? prod_x_s2[2*COORD_W-1:COORD_W] : '0;
		idx_y = pos_y_s2 ? prod_y_s2[2*COORD_W-1:COORD_W] : '0;
		bin_x = (idx_x > COORD_W'(GridSide - 1)) ? IdxW'(GridSide - 1) : idx_x[IdxW-1:0];
		bin_y = (idx_y > COORD_W'(GridSide - 1)) ? IdxW'(GridSide - 1) : idx_y[IdxW-1:0];
		hit_addr = AddrW'(32'(bin_x) * 32'(GridSide) + 32'(bin_y));
		oob = (32'(row_s2) >= 32'(GridSide)) || (32'(col_s2) >= 32'(GridSide));
		rd_addr = AddrW'(32'(row_s2) * 32'(GridSide) + 32'(col_s2));
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctl_s3   <= '0;
		end else if (advance) begin
			valid_s1       <= in_xfer;
			valid_s2       <= valid_s1;
			ctl_s3.valid   <= valid_s2;
			ctl_s3.is_read <= read_s2;
			ctl_s3.oob     <= read_s2 & oob;
		end
	end

	// Payload, advanced with the pipeline
	always_ff @(posedge clk) begin
		if (advance) begin
			read_s1      <= (action == ACT_READ);
			pos_x_s1     <= !diff_x[COORD_W] && (diff_x != '0);
			pos_y_s1     <= !diff_y[COORD_W] && (diff_y != '0);
			mag_x_s1     <= diff_x[COORD_W-1:0];
			mag_y_s1     <= diff_y[COORD_W-1:0];
			inten_s1     <= intensity;
			row_s1       <= read_row;
			col_s1       <= read_col;
			read_s2      <= read_s1;
			pos_x_s2     <= pos_x_s1;
			pos_y_s2     <= pos_y_s1;
			prod_x_s2    <= (2*COORD_W)'(mag_x_s1) * (2*COORD_W)'(scale_x);
			prod_y_s2    <= (2*COORD_W)'(mag_y_s1) * (2*COORD_W)'(scale_y);
			inten_s2     <= inten_s1;
			row_s2       <= row_s1;
			col_s2       <= col_s1;
			addr_s3      <= read_s2 ? rd_addr : hit_addr;
			intensity_s3 <= inten_s2;
		end
	end

endmodule

// ----- src/hhist_rmw.sv -----
// ----------------------------------------------------------------------------
// hhist_rmw
// Read-modify-write of one bin with write forwarding, result register and
// the clearing pass after reset.
// ----------------------------------------------------------------------------
module hhist_rmw #(
	parameter int Depth = 1024,
	parameter int AddrW = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hhist_pkg::item_ctl_t          ctl_s3,
	input  logic [AddrW-1:0]              addr_s3,
	input  logic [hhist_pkg::INTEN_W-1:0] intensity_s3,
	input  logic [hhist_pkg::BIN_W-1:0]   rdata,
	output hhist_pkg::pipe_stat_t         stat,
	output logic                          ram_we,
	output logic [AddrW-1:0]              ram_waddr,
	output logic [hhist_pkg::BIN_W-1:0]   ram_wdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [hhist_pkg::BIN_W-1:0]   m_axis_tdata
);

	import hhist_pkg::*;

	item_ctl_t        ctl_s4;
	logic [AddrW-1:0] addr_s4;
	logic [INTEN_W-1:0] inten_s4;
	logic             fwd_q;
	logic [AddrW-1:0] fwd_addr_q;
	logic [BIN_W-1:0] fwd_data_q;
	logic             clr_busy_q;
	logic [AddrW-1:0] clr_addr_q;
	logic             out_valid_q;
	logic [BIN_W-1:0] out_data_q;

	logic             advance;
	logic [BIN_W-1:0] old_val;
	logic [BIN_W:0]   sum;
	logic [BIN_W-1:0] new_val;
	logic             item_wr;
	logic             result;
	logic [BIN_W-1:0] result_val;

	// Move only when the result register is free or being drained
	assign advance = !out_valid_q || m_axis_tready;
	assign stat.advance  = advance;
	assign stat.clearing = clr_busy_q;

	// Modify: forward the value written at the last step if it hit this bin
	always_comb begin
		old_val = (fwd_q && (fwd_addr_q == addr_s4)) ? fwd_data_q : rdata;
		sum     = {1'b0, old_val} + (BIN_W + 1)'(inten_s4);
		if (ctl_s4.is_read) begin
			new_val = '0;
		end else begin
			new_val = sum[BIN_W] ? '1 : sum[BIN_W-1:0];
		end
		item_wr    = ctl_s4.valid && !(ctl_s4.is_read && ctl_s4.oob);
		result     = ctl_s4.valid && ctl_s4.is_read;
		result_val = ctl_s4.oob ? '0 : old_val;
	end

	// Write port: clearing pass first, then item write-back
	always_comb begin
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = advance && item_wr;
			ram_waddr = addr_s4;
			ram_wdata = new_val;
		end
	end

	// Clearing pass over every bin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AddrW'(Depth - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Stage 4 control, forwarding flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4      <= '0;
			fwd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			ctl_s4      <= ctl_s3;
			fwd_q       <= item_wr;
			out_valid_q <= result;
		end
	end

	// Stage 4 payload, forwarded data and result data
	always_ff @(posedge clk) begin
		if (advance) begin
			addr_s4    <= addr_s3;
			inten_s4   <= intensity_s3;
			fwd_addr_q <= addr_s4;
			fwd_data_q <= new_val;
			out_data_q <= result_val;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	// No item reaches the modify stage during the clearing pass
	a_no_item_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !ctl_s4.valid)
		else $error("item in modify stage during clearing pass");

	// No item write-back while the result register is stalled
	a_no_write_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready && !clr_busy_q) |-> !ram_we)
		else $error("bin written while pipeline stalled");

	// Read clears the bin, accumulate never decreases it
	a_write_value: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !clr_busy_q) |->
		(ctl_s4.is_read ? (ram_wdata == '0) : (ram_wdata >= old_val)))
		else $error("bad write-back value");

	// Clearing pass ends only after the last bin
	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> ($past(clr_addr_q) == AddrW'(Depth - 1)))
		else $error("clearing pass ended early");
`endif

endmodule

// ----- src/weighted_2d_hit_histogram_top.sv -----
// ----------------------------------------------------------------------------
// weighted_2d_hit_histogram_top
// Intensity-weighted GridSide x GridSide histogram of ray hit points.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transfer. tuser[0] is the action: accumulate
//   a hit point, or read and clear one bin. Accumulate items give no result;
//   each read gives one bin value on m_axis (zero for an index off the grid).
//   Registers (window edges, scales) are written through cfg_we / cfg_index /
//   cfg_data while the block is idle.
// Throughput: one item per cycle while the pipeline is not stalled and no
//   clearing pass runs. Bins live in one memory with a registered read; the
//   read-modify-write stage forwards the bin written in the previous step,
//   so hits on the same bin in consecutive cycles are summed without a bubble.
// Pipeline: a read result passes the stage 1 (offset), stage 2 (multiply),
//   stage 3 (clamp/address), memory read and result registers to m_axis.
// Reset: all bins are zeroed by a clearing pass over all GridSide*GridSide
//   bins (1,048,576 at the default size), one bin per cycle; s_axis_tready stays
//   low meanwhile. Register writes are taken at any time.
// Stall: while m_axis holds a result that is not taken, the whole pipeline
//   holds and s_axis_tready is low.
// ----------------------------------------------------------------------------
module weighted_2d_hit_histogram_top #(
	parameter int GridSide = hhist_pkg::GRID_SIDE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: point_x[31:0], point_y[63:32], intensity[79:64],
	//        read_row[89:80], read_col[99:90], zero fill[103:100]
	input  logic [hhist_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: action[0]
	input  logic [0:0]                        s_axis_tuser,
	// Result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata: bin_value[31:0]
	output logic [hhist_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// Register write port
	input  logic                              cfg_we,
	input  logic [hhist_pkg::CFGIX_W-1:0]     cfg_index,
	input  logic [hhist_pkg::CFG_W-1:0]       cfg_data
);

	import hhist_pkg::*;

	localparam int Depth = GridSide * GridSide;
	localparam int AddrW = $clog2(Depth);

	logic [CFG_W-1:0]   win_min_x_q, win_min_y_q, scale_x_q, scale_y_q;
	pipe_stat_t         stat;
	item_ctl_t          ctl_s3;
	logic [AddrW-1:0]   addr_s3;
	logic [INTEN_W-1:0] intensity_s3;
	logic               in_xfer;
	logic               ram_we;
	logic [AddrW-1:0]   ram_waddr;
	logic [BIN_W-1:0]   ram_wdata;
	logic [BIN_W-1:0]   ram_rdata;

	// Registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_min_x_q <= WIN_MIN_RESET;
			win_min_y_q <= WIN_MIN_RESET;
			scale_x_q   <= SCALE_RESET;
			scale_y_q   <= SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_WIN_MIN_X: win_min_x_q <= cfg_data;
				CFG_WIN_MIN_Y: win_min_y_q <= cfg_data;
				CFG_SCALE_X:   scale_x_q   <= cfg_data;
				CFG_SCALE_Y:   scale_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Take items only when the pipeline moves and the bins are clear
	assign s_axis_tready = stat.advance && !stat.clearing;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	hhist_addr #(
		.GridSide(GridSide),
		.AddrW   (AddrW)
	) u_addr (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (stat.advance),
		.in_xfer     (in_xfer),
		.action      (s_axis_tuser[0]),
		.point_x     (s_axis_tdata[31:0]),
		.point_y     (s_axis_tdata[63:32]),
		.intensity   (s_axis_tdata[79:64]),
		.read_row    (s_axis_tdata[89:80]),
		.read_col    (s_axis_tdata[99:90]),
		.win_min_x   (win_min_x_q),
		.win_min_y   (win_min_y_q),
		.scale_x     (scale_x_q),
		.scale_y     (scale_y_q),
		.ctl_s3      (ctl_s3),
		.addr_s3     (addr_s3),
		.intensity_s3(intensity_s3)
	);

	hhist_ram #(
		.Depth(Depth),
		.AddrW(AddrW),
		.DataW(BIN_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (stat.advance),
		.raddr(addr_s3),
		.rdata(ram_rdata)
	);

	hhist_rmw #(
		.Depth(Depth),
		.AddrW(AddrW)
	) u_rmw (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s3       (ctl_s3),
		.addr_s3      (addr_s3),
		.intensity_s3 (intensity_s3),
		.rdata        (ram_rdata),
		.stat         (stat),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule
